// File: src/assert_macros.svh
// assertion helpers, sampled on the block clock
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold whenever reset is released
`define BLZ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("blz assertion failed");

// condition must never be seen while reset is released
`define BLZ_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("blz forbidden condition seen");

`endif

// File: src/blz_pkg.sv
package blz_pkg;

  localparam int unsigned ROOM_W = 26;
  localparam int unsigned OFF_W  = 13;
  localparam int unsigned LEN_W  = 5;
  localparam int unsigned CNT_W  = 4;

  localparam logic [11:0]      OFF_MASK = 12'hFFF;
  localparam logic [OFF_W-1:0] OFF_BIAS = OFF_W'(2);
  localparam logic [LEN_W-1:0] LEN_BIAS = LEN_W'(3);
  localparam logic [CNT_W-1:0] FLAGS_PER_BYTE = CNT_W'(8);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LIT,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_REF   = 2'd1,
    STATUS_OVER  = 2'd2,
    STATUS_TRUNC = 2'd3
  } status_e;

  // controls from the sequencer to the history store
  typedef struct packed {
    logic             rearm;
    logic             rd_en;
    logic             wr_en;
    logic [OFF_W-1:0] off;
  } hist_ctrl_t;

endpackage

// File: src/blz_if.sv
// compressed byte channel
interface blz_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_end;

  modport source (output valid, output in_byte, output stream_end, input ready);
  modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

// decompressed result channel
interface blz_out_if;
  logic                      valid;
  logic                      ready;
  logic [7:0]                out_byte;
  logic [blz_pkg::ROOM_W-1:0] out_addr;
  logic                      byte_valid;
  logic [1:0]                status;
  logic                      run_last;
  logic                      stream_done;

  modport source (output valid, output out_byte, output out_addr, output byte_valid,
                  output status, output run_last, output stream_done, input ready);
  modport sink   (input valid, input out_byte, input out_addr, input byte_valid,
                  input status, input run_last, input stream_done, output ready);
endinterface

// configuration write channel
interface blz_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [blz_pkg::ROOM_W-1:0] output_room;

  modport source (output valid, output output_room, input ready);
  modport sink   (input valid, input output_room, output ready);
endinterface

// File: src/blz_hist.sv
module blz_hist #(
  parameter int unsigned HISTORY_DEPTH = 8192
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  blz_pkg::hist_ctrl_t ctrl_i,
  input  logic [7:0]          wr_data_i,
  output logic [7:0]          rd_data_o
);

  localparam int unsigned IW = $clog2(HISTORY_DEPTH);

  logic [7:0]    mem [HISTORY_DEPTH];
  logic [IW-1:0] cur_idx_q, cur_idx_d;
  logic [IW-1:0] wr_idx, rd_idx;
  logic [IW:0]   rd_sum;
  logic [7:0]    rd_data_q;

  // ring slot of the next lower position
  assign wr_idx = (cur_idx_q == '0) ? IW'(HISTORY_DEPTH - 1) : cur_idx_q - IW'(1);

  // source slot: current slot plus offset, wrapped once
  assign rd_sum = {1'b0, cur_idx_q} + (IW+1)'(ctrl_i.off);
  assign rd_idx = (rd_sum >= (IW+1)'(HISTORY_DEPTH)) ?
                  IW'(rd_sum - (IW+1)'(HISTORY_DEPTH)) : rd_sum[IW-1:0];

  // slot pointer follows the write position
  always_comb begin
    cur_idx_d = cur_idx_q;
    if (ctrl_i.rearm) begin
      cur_idx_d = '0;
    end else if (ctrl_i.wr_en) begin
      cur_idx_d = wr_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_idx_q <= '0;
    end else begin
      cur_idx_q <= cur_idx_d;
    end
  end

  // history ram, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[wr_idx] <= wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem[rd_idx];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: src/backward_lzss_decompressor_unit.sv
// literal result registered in ST_LIT after ST_DECODE, each copied byte in ST_COPY_WR
// per item: flag or pair high byte ST_DECODE only; literal then ST_LIT; error or end ST_EMIT
// pair: one history read then one write per copied byte, ST_COPY_RD then ST_COPY_WR
// throughput: one input item at a time, ready low until its results are registered
// reset: control state cleared, output_room 0, next byte is a flag byte
// history ram is not cleared; no clearing pass, ready right after reset
module backward_lzss_decompressor_unit #(
  parameter int unsigned HISTORY_DEPTH = 8192
) (
  input logic     clk_i,
  input logic     rst_ni,
  blz_cfg_if.sink cfg_i,
  blz_in_if.sink  in_i,
  blz_out_if.source out_o
);

  `include "assert_macros.svh"

  localparam int unsigned RW = blz_pkg::ROOM_W;

  blz_pkg::state_e  state_q, state_d;
  blz_pkg::status_e status_q, status_d;

  logic [RW-1:0]               room_q, room_d;
  logic [RW-1:0]               wp_q, wp_d;
  logic [7:0]                  flags_q, flags_d;
  logic [blz_pkg::CNT_W-1:0]   fleft_q, fleft_d;
  logic [7:0]                  phigh_q, phigh_d;
  logic                        ppend_q, ppend_d;
  logic                        halted_q, halted_d;
  logic [7:0]                  byte_q, byte_d;
  logic                        last_q, last_d;
  logic [blz_pkg::LEN_W-1:0]   cnt_q, cnt_d;
  logic [blz_pkg::OFF_W-1:0]   off_q, off_d;

  // output register
  logic                        ov_q, ov_d;
  logic [7:0]                  ob_q, ob_d;
  logic [RW-1:0]               oa_q, oa_d;
  logic                        obv_q, obv_d;
  blz_pkg::status_e            ost_q, ost_d;
  logic                        orl_q, orl_d;
  logic                        osd_q, osd_d;

  logic                        in_xfer, cfg_xfer, out_free;
  logic [15:0]                 pair_w;
  logic [blz_pkg::LEN_W-1:0]   pair_len;
  logic [blz_pkg::OFF_W-1:0]   pair_off;
  logic [RW:0]                 src_pos;
  logic                        over_err, ref_err;
  logic [RW-1:0]               wp_dec;
  logic                        cnt_last;
  logic                        in_copy;
  logic [7:0]                  rd_data;
  blz_pkg::hist_ctrl_t         hctrl;

  // handshakes
  assign in_i.ready  = (state_q == blz_pkg::ST_IDLE);
  assign cfg_i.ready = (state_q == blz_pkg::ST_IDLE);
  assign in_xfer     = in_i.valid && in_i.ready;
  assign cfg_xfer    = cfg_i.valid && cfg_i.ready;
  assign out_free    = !ov_q || out_o.ready;

  // pair decode and range checks
  assign pair_w   = {phigh_q, byte_q};
  assign pair_len = blz_pkg::LEN_W'(pair_w[15:12]) + blz_pkg::LEN_BIAS;
  assign pair_off = blz_pkg::OFF_W'(pair_w[11:0] & blz_pkg::OFF_MASK) + blz_pkg::OFF_BIAS;
  assign src_pos  = {1'b0, wp_q} + (RW+1)'(pair_off);
  assign over_err = (wp_q < RW'(pair_len));
  assign ref_err  = (src_pos >= {1'b0, room_q});
  assign wp_dec   = wp_q - RW'(1);
  assign cnt_last = (cnt_q == blz_pkg::LEN_W'(1));
  assign in_copy  = (state_q == blz_pkg::ST_COPY_RD) || (state_q == blz_pkg::ST_COPY_WR);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      blz_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_d = blz_pkg::ST_DECODE;
        end
      end
      blz_pkg::ST_DECODE: begin
        if (halted_q) begin
          state_d = blz_pkg::ST_IDLE;
        end else if (fleft_q == '0) begin
          state_d = last_q ? blz_pkg::ST_EMIT : blz_pkg::ST_IDLE;
        end else if (ppend_q) begin
          state_d = (over_err || ref_err) ? blz_pkg::ST_EMIT : blz_pkg::ST_COPY_RD;
        end else if (wp_q != '0) begin
          if (!flags_q[7]) begin
            state_d = blz_pkg::ST_LIT;
          end else begin
            state_d = last_q ? blz_pkg::ST_EMIT : blz_pkg::ST_IDLE;
          end
        end else begin
          state_d = last_q ? blz_pkg::ST_EMIT : blz_pkg::ST_IDLE;
        end
      end
      blz_pkg::ST_LIT: begin
        if (out_free) begin
          state_d = blz_pkg::ST_IDLE;
        end
      end
      blz_pkg::ST_COPY_RD: begin
        state_d = blz_pkg::ST_COPY_WR;
      end
      blz_pkg::ST_COPY_WR: begin
        if (out_free) begin
          state_d = cnt_last ? blz_pkg::ST_IDLE : blz_pkg::ST_COPY_RD;
        end
      end
      blz_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = blz_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = blz_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    room_d   = room_q;
    wp_d     = wp_q;
    flags_d  = flags_q;
    fleft_d  = fleft_q;
    phigh_d  = phigh_q;
    ppend_d  = ppend_q;
    halted_d = halted_q;
    byte_d   = byte_q;
    last_d   = last_q;
    cnt_d    = cnt_q;
    off_d    = off_q;
    status_d = status_q;
    ov_d     = ov_q && !out_o.ready;
    ob_d     = ob_q;
    oa_d     = oa_q;
    obv_d    = obv_q;
    ost_d    = ost_q;
    orl_d    = orl_q;
    osd_d    = osd_q;
    hctrl    = '{rearm: cfg_xfer, rd_en: 1'b0, wr_en: 1'b0, off: off_q};

    case (state_q)
      blz_pkg::ST_IDLE: begin
        // new stream on a config transfer
        if (cfg_xfer) begin
          room_d   = cfg_i.output_room;
          wp_d     = cfg_i.output_room;
          flags_d  = '0;
          fleft_d  = '0;
          phigh_d  = '0;
          ppend_d  = 1'b0;
          halted_d = 1'b0;
        end
        if (in_xfer) begin
          byte_d = in_i.in_byte;
          last_d = in_i.stream_end;
        end
      end
      blz_pkg::ST_DECODE: begin
        status_d = blz_pkg::STATUS_OK;
        if (!halted_q) begin
          if (fleft_q == '0) begin
            flags_d = byte_q;
            fleft_d = blz_pkg::FLAGS_PER_BYTE;
          end else if (ppend_q) begin
            ppend_d = 1'b0;
            flags_d = {flags_q[6:0], 1'b0};
            fleft_d = fleft_q - blz_pkg::CNT_W'(1);
            cnt_d   = pair_len;
            off_d   = pair_off;
            if (over_err) begin
              status_d = blz_pkg::STATUS_OVER;
            end else if (ref_err) begin
              status_d = blz_pkg::STATUS_REF;
            end
          end else if (wp_q != '0 && flags_q[7]) begin
            if (last_q) begin
              status_d = blz_pkg::STATUS_TRUNC;
            end else begin
              phigh_d = byte_q;
              ppend_d = 1'b1;
            end
          end
        end
      end
      blz_pkg::ST_LIT: begin
        // literal goes to history and out
        if (out_free) begin
          hctrl.wr_en = 1'b1;
          wp_d        = wp_dec;
          flags_d     = {flags_q[6:0], 1'b0};
          fleft_d     = fleft_q - blz_pkg::CNT_W'(1);
          halted_d    = last_q;
          ov_d        = 1'b1;
          ob_d        = byte_q;
          oa_d        = wp_dec;
          obv_d       = 1'b1;
          ost_d       = blz_pkg::STATUS_OK;
          orl_d       = 1'b1;
          osd_d       = last_q;
        end
      end
      blz_pkg::ST_COPY_RD: begin
        hctrl.rd_en = 1'b1;
      end
      blz_pkg::ST_COPY_WR: begin
        // copied byte goes to history and out
        if (out_free) begin
          hctrl.wr_en = 1'b1;
          wp_d        = wp_dec;
          cnt_d       = cnt_q - blz_pkg::LEN_W'(1);
          ov_d        = 1'b1;
          ob_d        = rd_data;
          oa_d        = wp_dec;
          obv_d       = 1'b1;
          ost_d       = blz_pkg::STATUS_OK;
          orl_d       = cnt_last;
          osd_d       = cnt_last && last_q;
          if (cnt_last) begin
            halted_d = last_q;
          end
        end
      end
      blz_pkg::ST_EMIT: begin
        // status-only result closes the stream
        if (out_free) begin
          halted_d = 1'b1;
          ov_d     = 1'b1;
          ob_d     = '0;
          oa_d     = wp_q;
          obv_d    = 1'b0;
          ost_d    = status_q;
          orl_d    = 1'b1;
          osd_d    = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= blz_pkg::ST_IDLE;
      room_q   <= '0;
      wp_q     <= '0;
      flags_q  <= '0;
      fleft_q  <= '0;
      phigh_q  <= '0;
      ppend_q  <= 1'b0;
      halted_q <= 1'b0;
      cnt_q    <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      room_q   <= room_d;
      wp_q     <= wp_d;
      flags_q  <= flags_d;
      fleft_q  <= fleft_d;
      phigh_q  <= phigh_d;
      ppend_q  <= ppend_d;
      halted_q <= halted_d;
      cnt_q    <= cnt_d;
      ov_q     <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    byte_q   <= byte_d;
    last_q   <= last_d;
    off_q    <= off_d;
    status_q <= status_d;
    ob_q     <= ob_d;
    oa_q     <= oa_d;
    obv_q    <= obv_d;
    ost_q    <= ost_d;
    orl_q    <= orl_d;
    osd_q    <= osd_d;
  end

  blz_hist #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (hctrl),
    .wr_data_i ((state_q == blz_pkg::ST_LIT) ? byte_q : rd_data),
    .rd_data_o (rd_data)
  );

  assign out_o.valid       = ov_q;
  assign out_o.out_byte    = ob_q;
  assign out_o.out_addr    = oa_q;
  assign out_o.byte_valid  = obv_q;
  assign out_o.status      = ost_q;
  assign out_o.run_last    = orl_q;
  assign out_o.stream_done = osd_q;

  // copy never runs past the bottom of the output
  `BLZ_ASSERT(a_copy_room, in_copy |-> (cnt_q != '0 && RW'(cnt_q) <= wp_q))
  // status-only results always end the item and the stream
  `BLZ_ASSERT(a_status_closes, (ov_q && !obv_q) |-> (orl_q && osd_q))
  // a data byte carrying an error code is never produced
  `BLZ_ASSERT_NEVER(a_byte_ok, ov_q && obv_q && (ost_q != blz_pkg::STATUS_OK))

endmodule

// File: tb/tb_backward_lzss_decompressor_unit.sv
`timescale 1ns / 1ps

module tb_backward_lzss_decompressor_unit;

  localparam int unsigned HIST_DEPTH  = 8192;
  localparam int unsigned ROOM_MAX    = (1 << blz_pkg::ROOM_W) - 1;
  localparam int unsigned RAND_ITEMS  = 210;
  localparam int unsigned SETTLE      = 64;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } comp_byte_t;

  typedef struct {
    logic [7:0]                 out_byte;
    logic [blz_pkg::ROOM_W-1:0] out_addr;
    logic                       byte_valid;
    blz_pkg::status_e           status;
    logic                       run_last;
    logic                       stream_done;
  } blz_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  blz_in_if  in_if ();
  blz_out_if out_if ();
  blz_cfg_if cfg_if ();

  backward_lzss_decompressor_unit #(
    .HISTORY_DEPTH(HIST_DEPTH)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // compressed bytes waiting to be driven, decompressed results still due
  comp_byte_t  pending_bytes_q[$];
  blz_result_t predicted_out_q[$];

  // decoder state as predicted
  logic [blz_pkg::ROOM_W-1:0] out_room;
  logic [blz_pkg::ROOM_W-1:0] wr_pos;
  logic [7:0]                 flag_reg;
  logic [3:0]                 flags_left;
  logic [7:0]                 pair_hi;
  bit                         pair_pend;
  bit                         halted;
  logic [7:0]                 hist [HIST_DEPTH];

  int unsigned fed_cnt = 0;
  int unsigned taken_cnt = 0;
  int unsigned live_cnt = 0;
  int unsigned res_cnt = 0;
  int unsigned stream_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          in_taken = 1'b0;
  comp_byte_t  drv_byte;
  blz_result_t want;

  function automatic void restart_stream();
    flag_reg   = '0;
    flags_left = '0;
    pair_hi    = '0;
    pair_pend  = 1'b0;
    halted     = 1'b0;
    wr_pos     = out_room;
  endfunction

  // decode one compressed byte and queue the results it produces
  function automatic void decode_byte(input logic [7:0] b, input logic last);
    blz_result_t      res_q[$];
    logic [15:0]      w;
    int unsigned      len;
    int unsigned      off;
    int unsigned      src;
    logic [7:0]       v;
    bit               has_err;
    blz_pkg::status_e err;
    has_err = 1'b0;
    err = blz_pkg::STATUS_OK;
    if (halted) return;
    live_cnt++;
    if (flags_left == 0) begin
      flag_reg = b;
      flags_left = 4'd8;
    end else if (pair_pend) begin
      w = {pair_hi, b};
      len = int'(w[15:12]) + 3;
      off = int'(w[11:0]) + 2;
      pair_pend = 1'b0;
      flag_reg = {flag_reg[6:0], 1'b0};
      flags_left = flags_left - 4'd1;
      if (wr_pos < len) begin
        has_err = 1'b1;
        err = blz_pkg::STATUS_OVER;
      end else begin
        for (int j = 0; j < len; j++) begin
          src = wr_pos + off;
          if (src >= out_room) begin
            has_err = 1'b1;
            err = blz_pkg::STATUS_REF;
            break;
          end
          v = hist[src % HIST_DEPTH];
          wr_pos = wr_pos - 1'b1;
          hist[wr_pos % HIST_DEPTH] = v;
          res_q.insert(res_q.size(), '{v, wr_pos, 1'b1, blz_pkg::STATUS_OK, 1'b0, 1'b0});
        end
      end
    end else if (wr_pos != 0) begin
      if (!flag_reg[7]) begin
        wr_pos = wr_pos - 1'b1;
        hist[wr_pos % HIST_DEPTH] = b;
        res_q.insert(res_q.size(), '{b, wr_pos, 1'b1, blz_pkg::STATUS_OK, 1'b0, 1'b0});
        flag_reg = {flag_reg[6:0], 1'b0};
        flags_left = flags_left - 4'd1;
      end else if (last) begin
        has_err = 1'b1;
        err = blz_pkg::STATUS_TRUNC;
      end else begin
        pair_hi = b;
        pair_pend = 1'b1;
      end
    end
    // error or end of stream closes the run
    if (has_err) begin
      res_q.insert(res_q.size(), '{8'h00, wr_pos, 1'b0, err, 1'b0, 1'b1});
      halted = 1'b1;
    end else if (last) begin
      if (res_q.size() == 0)
        res_q.insert(0, '{8'h00, wr_pos, 1'b0, blz_pkg::STATUS_OK, 1'b0, 1'b1});
      else res_q[res_q.size()-1].stream_done = 1'b1;
      halted = 1'b1;
    end
    if (res_q.size() != 0) res_q[res_q.size()-1].run_last = 1'b1;
    foreach (res_q[i]) predicted_out_q.insert(predicted_out_q.size(), res_q[i]);
  endfunction

  task automatic report_mismatch(input string msg);
    err_cnt++;
    $display("mismatch: %s", msg);
  endtask

  // monitor: check result transfers, predict on config and input transfers
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_room = '0;
      restart_stream();
    end else begin
      if (out_if.valid && out_if.ready) begin
        res_cnt++;
        if (predicted_out_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result byte %02h addr %0d status %0d",
                                    out_if.out_byte, out_if.out_addr, out_if.status));
        end else begin
          want = predicted_out_q.pop_front();
          if (out_if.out_byte !== want.out_byte || out_if.out_addr !== want.out_addr ||
              out_if.byte_valid !== want.byte_valid || out_if.status !== want.status ||
              out_if.run_last !== want.run_last || out_if.stream_done !== want.stream_done)
            report_mismatch($sformatf(
              "result %0d got %02h @%0d v%b s%0d l%b d%b, want %02h @%0d v%b s%0d l%b d%b",
              res_cnt, out_if.out_byte, out_if.out_addr, out_if.byte_valid, out_if.status,
              out_if.run_last, out_if.stream_done, want.out_byte, want.out_addr,
              want.byte_valid, want.status, want.run_last, want.stream_done));
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        out_room = cfg_if.output_room;
        restart_stream();
        stream_cnt++;
      end
      in_taken = in_if.valid && in_if.ready;
      if (in_taken) begin
        taken_cnt++;
        decode_byte(in_if.in_byte, in_if.stream_end);
      end
    end
  end

  // driver: new byte or idle once the last one was taken, random receiver stall
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid      <= 1'b0;
      in_if.in_byte    <= '0;
      in_if.stream_end <= 1'b0;
      out_if.ready     <= 1'b0;
    end else begin
      if (!in_if.valid || in_taken) begin
        if (pending_bytes_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          drv_byte = pending_bytes_q.pop_front();
          in_if.valid      <= 1'b1;
          in_if.in_byte    <= drv_byte.data;
          in_if.stream_end <= drv_byte.last;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("backward_lzss_decompressor_unit regression: fail");
      $finish;
    end
  end

  task automatic add_byte(input logic [7:0] b, input logic last);
    pending_bytes_q.insert(pending_bytes_q.size(), '{b, last});
    fed_cnt++;
  endtask

  task automatic write_output_room(input logic [blz_pkg::ROOM_W-1:0] room);
    @(negedge clk_i);
    cfg_if.valid       <= 1'b1;
    cfg_if.output_room <= room;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // all bytes taken, all results in, then let trailing work settle
  task automatic wait_idle();
    do @(posedge clk_i);
    while (taken_cnt != fed_cnt || predicted_out_q.size() != 0 || pending_bytes_q.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_SEND: begin
        send_idle_pct = 59;
        recv_stall_pct = 0;
      end
      IDLE_RECV: begin
        send_idle_pct = 0;
        recv_stall_pct = 59;
      end
      IDLE_BOTH: begin
        send_idle_pct = 25;
        recv_stall_pct = 25;
      end
      default: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  // one compressed stream: groups of a flag byte and up to eight tokens, legal
  // references when clean, random pairs and cut-off endings mixed in otherwise
  task automatic build_stream(input int unsigned room, input bit clean);
    comp_byte_t  seq[$];
    logic [7:0]  tok_hi [8];
    logic [7:0]  tok_lo [8];
    bit          tok_pair [8];
    logic [7:0]  flag;
    int unsigned made;
    int unsigned left;
    int unsigned groups;
    int unsigned ntok;
    int unsigned len;
    int unsigned back;
    int unsigned pick;
    made = 0;
    left = room;
    groups = $urandom_range(1, 5);
    for (int g = 0; g < groups; g++) begin
      if (left == 0 && g != 0) break;
      ntok = 0;
      flag = 8'($urandom);
      for (int k = 0; k < 8; k++) begin
        if (left == 0) break;
        if (made >= 3 && left >= 3 && $urandom_range(0, 1) == 1) begin
          len = $urandom_range(3, (left < 18) ? left : 18);
          back = $urandom_range(0, (made - 3 < 4095) ? made - 3 : 4095);
          if (!clean && $urandom_range(0, 3) == 0) begin
            tok_hi[k] = 8'($urandom);
            tok_lo[k] = 8'($urandom);
          end else begin
            tok_hi[k] = {4'(len - 3), 4'(back >> 8)};
            tok_lo[k] = 8'(back);
          end
          tok_pair[k] = 1'b1;
          flag[7-k] = 1'b1;
          made += len;
          left -= len;
        end else if (!clean && $urandom_range(0, 5) == 0) begin
          tok_hi[k] = 8'($urandom);
          tok_lo[k] = 8'($urandom);
          tok_pair[k] = 1'b1;
          flag[7-k] = 1'b1;
          len = int'(tok_hi[k][7:4]) + 3;
          made += len;
          left = (left > len) ? left - len : 0;
        end else begin
          tok_hi[k] = 8'($urandom);
          tok_pair[k] = 1'b0;
          flag[7-k] = 1'b0;
          made++;
          left--;
        end
        ntok++;
      end
      seq.insert(seq.size(), '{flag, 1'b0});
      for (int k = 0; k < ntok; k++) begin
        seq.insert(seq.size(), '{tok_hi[k], 1'b0});
        if (tok_pair[k]) seq.insert(seq.size(), '{tok_lo[k], 1'b0});
      end
    end
    // ending: cut-off pair, lone flag byte, or last token or extra bytes marked last
    pick = $urandom_range(0, 5);
    if (!clean && pick == 0) begin
      seq.insert(seq.size(), '{8'h80 | 8'($urandom), 1'b0});
      seq.insert(seq.size(), '{8'($urandom), 1'b1});
    end else if (pick == 1) begin
      seq.insert(seq.size(), '{8'($urandom), 1'b1});
    end else begin
      if (left == 0) repeat ($urandom_range(0, 3)) seq.insert(seq.size(), '{8'($urandom), 1'b0});
      seq[seq.size()-1].last = 1'b1;
    end
    // trailing bytes after the stream is closed
    repeat ($urandom_range(0, 2)) seq.insert(seq.size(), '{8'($urandom), 1'($urandom)});
    foreach (seq[i]) add_byte(seq[i].data, seq[i].last);
  endtask

  initial begin
    int unsigned phase;
    int unsigned room;
    cfg_if.valid       = 1'b0;
    cfg_if.output_room = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: no room at all, tokens ignored, end gives a status-only result
    set_idling(IDLE_NONE);
    write_output_room('0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b1);
    wait_idle();

    // largest room: three literals then a shortest, nearest copy ending the stream
    write_output_room(blz_pkg::ROOM_W'(ROOM_MAX));
    add_byte(8'h10, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hA5, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b1);
    wait_idle();

    // longest pair before any byte exists: reference beyond produced data
    write_output_room(blz_pkg::ROOM_W'(20));
    add_byte(8'h80, 1'b0);
    add_byte(8'hF0, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h3C, 1'b1);
    wait_idle();

    // pair longer than the room left: output overflow
    write_output_room(blz_pkg::ROOM_W'(4));
    add_byte(8'h10, 1'b0);
    add_byte(8'h01, 1'b0);
    add_byte(8'h02, 1'b0);
    add_byte(8'h03, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    wait_idle();

    // pair high byte marked as the last one: truncated pair
    write_output_room(blz_pkg::ROOM_W'(10));
    add_byte(8'h80, 1'b0);
    add_byte(8'h7F, 1'b1);
    wait_idle();

    // stream ends on a flag byte with nothing produced
    write_output_room(blz_pkg::ROOM_W'(5));
    add_byte(8'h55, 1'b1);
    wait_idle();

    // room runs out, later token bytes are ignored
    write_output_room(blz_pkg::ROOM_W'(2));
    add_byte(8'h00, 1'b0);
    add_byte(8'h11, 1'b0);
    add_byte(8'h22, 1'b0);
    add_byte(8'h33, 1'b0);
    add_byte(8'h44, 1'b1);
    wait_idle();

    // random streams, idling pattern rotating per stream
    phase = 0;
    while (fed_cnt < RAND_ITEMS) begin
      set_idling(idle_mode_e'(phase % 4));
      case ($urandom_range(0, 15))
        0: room = 0;
        1, 2: room = ROOM_MAX;
        3, 4: room = $urandom & ROOM_MAX;
        default: room = $urandom_range(0, 400);
      endcase
      write_output_room(blz_pkg::ROOM_W'(room));
      build_stream(room, $urandom_range(0, 4) != 0);
      wait_idle();
      phase++;
    end

    $display("covered %0d streams, %0d compressed bytes decoded, %0d results checked",
             stream_cnt, live_cnt, res_cnt);
    $display("idling patterns rotated over %0d random streams, %0d cycles", phase, cycle_cnt);
    if (err_cnt == 0) begin
      $display("backward_lzss_decompressor_unit regression: pass");
    end else begin
      $display("backward_lzss_decompressor_unit regression: fail");
    end
    $finish;
  end

endmodule
